### src/dahs_pkg.sv
// Shared types, codes and reset values for the dual-axis homing sequencer.
// No dependencies; used by dahs_axis and dual_axis_homing_sequencer.
package dahs_pkg;

    // Item codes carried in s_tuser
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_FORCE = 2'd2;

    // Run result codes
    localparam logic [1:0] RES_OK      = 2'd0;
    localparam logic [1:0] RES_AXIS1   = 2'd1;
    localparam logic [1:0] RES_AXIS2   = 2'd2;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [1:0] REG_MAX_ANGLE = 2'd1;
    localparam logic [1:0] REG_TIMEOUT  = 2'd2;

    localparam int DEBOUNCE_W  = 4;
    localparam int MAX_ANGLE_W = 23;
    localparam int TIMEOUT_W   = 24;
    localparam int RUN_W       = 4;

    localparam logic [DEBOUNCE_W-1:0]  DEBOUNCE_RST  = 4'd3;
    localparam logic [MAX_ANGLE_W-1:0] MAX_ANGLE_RST = 23'd5000;
    localparam logic [TIMEOUT_W-1:0]   TIMEOUT_RST   = 24'd10000;

    localparam int ANGLE_WIDTH_DEF = 24;
    localparam int TIMER_WIDTH_DEF = 24;

    typedef enum logic [1:0] {
        OUT_PENDING  = 2'd0,
        OUT_OBSTACLE = 2'd1,
        OUT_LIMIT    = 2'd2,
        OUT_TIMEOUT  = 2'd3
    } outcome_t;

    // Per-axis state handed between the top level and the axis checker
    typedef struct packed {
        outcome_t         outcome;
        logic [RUN_W-1:0] high_run;
    } axis_state_t;

    typedef struct packed {
        logic [DEBOUNCE_W-1:0]  debounce_count;
        logic [MAX_ANGLE_W-1:0] max_angle;
    } axis_cfg_t;

endpackage

### src/dahs_axis.sv
// Per-axis obstacle and limit check for one sample tick.
// Depends on dahs_pkg for the outcome codes and state/config structs.
module dahs_axis #(
    parameter int ANGLE_WIDTH = dahs_pkg::ANGLE_WIDTH_DEF
) (
    input  dahs_pkg::axis_state_t    cur,
    input  dahs_pkg::axis_cfg_t      cfg,
    input  logic                     stall,
    input  logic [ANGLE_WIDTH-1:0]   angle,
    output dahs_pkg::axis_state_t    nxt
);

    localparam int CMP_W = (ANGLE_WIDTH > dahs_pkg::MAX_ANGLE_W) ?
                           ANGLE_WIDTH : dahs_pkg::MAX_ANGLE_W;

    logic [ANGLE_WIDTH-1:0]      magnitude;
    logic [dahs_pkg::RUN_W-1:0]  run_next;
    logic                        obstacle;
    logic                        at_limit;

    // The most negative angle maps to 2^(ANGLE_WIDTH-1), which still fits unsigned
    assign magnitude = angle[ANGLE_WIDTH-1] ? (~angle + {{(ANGLE_WIDTH-1){1'b0}}, 1'b1})
                                            : angle;

    always_comb
    begin
        if (!stall)
        begin
            run_next = '0;
        end
        else if (cur.high_run != {dahs_pkg::RUN_W{1'b1}})
        begin
            run_next = cur.high_run + {{(dahs_pkg::RUN_W-1){1'b0}}, 1'b1};
        end
        else
        begin
            run_next = cur.high_run;
        end
    end

    assign obstacle = stall && (run_next >= cfg.debounce_count);
    assign at_limit = CMP_W'(magnitude) >= CMP_W'(cfg.max_angle);

    always_comb
    begin
        nxt = cur;
        // Freeze everything once this axis has finished
        if (cur.outcome == dahs_pkg::OUT_PENDING)
        begin
            nxt.high_run = run_next;
            if (obstacle)
            begin
                nxt.outcome = dahs_pkg::OUT_OBSTACLE;
            end
            else if (at_limit)
            begin
                nxt.outcome = dahs_pkg::OUT_LIMIT;
            end
        end
    end

endmodule

### src/dual_axis_homing_sequencer.sv
// Dual-axis homing sequencer: input register, one pass of compare logic, result register.
// A result reaches m_tdata through the input register, then the result register.
// Throughput: one item per cycle, limited only by m_tready backpressure.
// Reset (rst_n, asynchronous): run state cleared, homed low, registers at defaults.
// Depends on dahs_pkg and dahs_axis.
module dual_axis_homing_sequencer #(
    parameter int ANGLE_WIDTH = dahs_pkg::ANGLE_WIDTH_DEF,
    parameter int TIMER_WIDTH = dahs_pkg::TIMER_WIDTH_DEF,
    localparam int IN_BITS    = 2 + 2 * ANGLE_WIDTH,
    localparam int IN_W       = ((IN_BITS + 7) / 8) * 8
) (
    input  logic            clk,
    input  logic            rst_n,
    // Input stream
    input  logic            s_tvalid,
    output logic            s_tready,
    // s_tdata: stall_m1, stall_m2, angle_m1[ANGLE_WIDTH], angle_m2[ANGLE_WIDTH], zero pad
    input  logic [IN_W-1:0] s_tdata,
    // s_tuser: opcode[2]
    input  logic [1:0]      s_tuser,
    // Result stream
    output logic            m_tvalid,
    input  logic            m_tready,
    // m_tdata: drive_m1, drive_m2, zero_angles, busy_res, finished, result_code[2],
    //          outcome_m1[2], outcome_m2[2], homed_flag, zero pad
    output logic [15:0]     m_tdata,
    // Configuration
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [3:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    localparam int TO_CMP_W = (TIMER_WIDTH > dahs_pkg::TIMEOUT_W) ?
                              TIMER_WIDTH : dahs_pkg::TIMEOUT_W;

    // Configuration registers
    logic [dahs_pkg::DEBOUNCE_W-1:0]  debounce_reg;
    logic [dahs_pkg::MAX_ANGLE_W-1:0] max_angle_reg;
    logic [dahs_pkg::TIMEOUT_W-1:0]   timeout_reg;
    logic                             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg  <= dahs_pkg::DEBOUNCE_RST;
            max_angle_reg <= dahs_pkg::MAX_ANGLE_RST;
            timeout_reg   <= dahs_pkg::TIMEOUT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                dahs_pkg::REG_DEBOUNCE:  debounce_reg  <= pwdata[dahs_pkg::DEBOUNCE_W-1:0];
                dahs_pkg::REG_MAX_ANGLE: max_angle_reg <= pwdata[dahs_pkg::MAX_ANGLE_W-1:0];
                dahs_pkg::REG_TIMEOUT:   timeout_reg   <= pwdata[dahs_pkg::TIMEOUT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            dahs_pkg::REG_DEBOUNCE:  prdata = 32'(debounce_reg);
            dahs_pkg::REG_MAX_ANGLE: prdata = 32'(max_angle_reg);
            dahs_pkg::REG_TIMEOUT:   prdata = 32'(timeout_reg);
            default:                 prdata = '0;
        endcase
    end

    // Pipeline handshake
    logic in_valid_reg;
    logic out_valid_reg;
    logic advance;
    logic fire;

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;

    // Input register
    logic [1:0]             op_reg;
    logic                   stall1_reg;
    logic                   stall2_reg;
    logic [ANGLE_WIDTH-1:0] angle1_reg;
    logic [ANGLE_WIDTH-1:0] angle2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            op_reg     <= s_tuser;
            stall1_reg <= s_tdata[0];
            stall2_reg <= s_tdata[1];
            angle1_reg <= s_tdata[2 +: ANGLE_WIDTH];
            angle2_reg <= s_tdata[2 + ANGLE_WIDTH +: ANGLE_WIDTH];
        end
    end

    // Run state
    logic                    homed_reg, homed_next;
    logic                    running_reg, running_next;
    logic [TIMER_WIDTH-1:0]  elapsed_reg, elapsed_next;
    dahs_pkg::axis_state_t   axis1_reg, axis1_next;
    dahs_pkg::axis_state_t   axis2_reg, axis2_next;
    dahs_pkg::axis_state_t   axis1_chk, axis2_chk;
    dahs_pkg::axis_cfg_t     axis_cfg;
    logic [TIMER_WIDTH-1:0]  elapsed_inc;
    logic                    timed_out;
    logic                    zero_now;
    logic                    fin_now;
    logic [1:0]              code_now;

    assign axis_cfg.debounce_count = debounce_reg;
    assign axis_cfg.max_angle      = max_angle_reg;

    dahs_axis #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_axis1 (
        .cur   (axis1_reg),
        .cfg   (axis_cfg),
        .stall (stall1_reg),
        .angle (angle1_reg),
        .nxt   (axis1_chk)
    );

    dahs_axis #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_axis2 (
        .cur   (axis2_reg),
        .cfg   (axis_cfg),
        .stall (stall2_reg),
        .angle (angle2_reg),
        .nxt   (axis2_chk)
    );

    // Saturate the tick counter, then compare it against the timeout
    assign elapsed_inc = (elapsed_reg == {TIMER_WIDTH{1'b1}}) ? elapsed_reg
                       : elapsed_reg + {{(TIMER_WIDTH-1){1'b0}}, 1'b1};
    assign timed_out   = TO_CMP_W'(elapsed_inc) > TO_CMP_W'(timeout_reg);

    always_comb
    begin
        homed_next   = homed_reg;
        running_next = running_reg;
        elapsed_next = elapsed_reg;
        axis1_next   = axis1_reg;
        axis2_next   = axis2_reg;
        zero_now     = 1'b0;
        fin_now      = 1'b0;
        code_now     = dahs_pkg::RES_OK;

        unique case (op_reg)
            dahs_pkg::OP_START:
            begin
                homed_next          = 1'b0;
                running_next        = 1'b1;
                elapsed_next        = '0;
                axis1_next.outcome  = dahs_pkg::OUT_PENDING;
                axis1_next.high_run = '0;
                axis2_next.outcome  = dahs_pkg::OUT_PENDING;
                axis2_next.high_run = '0;
                zero_now            = 1'b1;
            end
            dahs_pkg::OP_FORCE:
            begin
                if (!running_reg)
                begin
                    homed_next = 1'b1;
                    zero_now   = 1'b1;
                end
            end
            dahs_pkg::OP_TICK:
            begin
                if (running_reg)
                begin
                    elapsed_next = elapsed_inc;
                    axis1_next   = axis1_chk;
                    axis2_next   = axis2_chk;
                    if (timed_out)
                    begin
                        if (axis1_chk.outcome == dahs_pkg::OUT_PENDING)
                        begin
                            axis1_next.outcome = dahs_pkg::OUT_TIMEOUT;
                        end
                        if (axis2_chk.outcome == dahs_pkg::OUT_PENDING)
                        begin
                            axis2_next.outcome = dahs_pkg::OUT_TIMEOUT;
                        end
                    end
                    if (axis1_next.outcome != dahs_pkg::OUT_PENDING &&
                        axis2_next.outcome != dahs_pkg::OUT_PENDING)
                    begin
                        running_next = 1'b0;
                        fin_now      = 1'b1;
                        if (axis1_next.outcome != dahs_pkg::OUT_OBSTACLE)
                        begin
                            code_now = dahs_pkg::RES_AXIS1;
                        end
                        else if (axis2_next.outcome != dahs_pkg::OUT_OBSTACLE)
                        begin
                            code_now = dahs_pkg::RES_AXIS2;
                        end
                        else
                        begin
                            homed_next = 1'b1;
                            zero_now   = 1'b1;
                        end
                    end
                end
            end
            default: ;  // reserved code: hold state
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            homed_reg           <= 1'b0;
            running_reg         <= 1'b0;
            elapsed_reg         <= '0;
            axis1_reg.outcome   <= dahs_pkg::OUT_PENDING;
            axis1_reg.high_run  <= '0;
            axis2_reg.outcome   <= dahs_pkg::OUT_PENDING;
            axis2_reg.high_run  <= '0;
        end
        else if (fire)
        begin
            homed_reg   <= homed_next;
            running_reg <= running_next;
            elapsed_reg <= elapsed_next;
            axis1_reg   <= axis1_next;
            axis2_reg   <= axis2_next;
        end
    end

    // Result register
    logic [15:0] result_next;
    logic [15:0] result_reg;

    assign result_next = {
        4'b0000,
        homed_next,
        axis2_next.outcome,
        axis1_next.outcome,
        code_now,
        fin_now,
        running_next,
        zero_now,
        running_next && (axis2_next.outcome == dahs_pkg::OUT_PENDING),
        running_next && (axis1_next.outcome == dahs_pkg::OUT_PENDING)
    };

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= result_next;
        end
    end

    assign m_tdata = result_reg;

endmodule
